// ===== hw/rtl/refalloc_pkg.sv =====
// Package for the per-CPU free-list page allocator.
// Holds request/response structs, opcodes and status codes; no dependencies.
`timescale 1ns / 1ps

package refalloc_pkg;

  // Opcodes of a request
  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_FREE    = 3'd1;
  localparam logic [2:0] OP_INC     = 3'd2;
  localparam logic [2:0] OP_QUERY   = 3'd3;
  localparam logic [2:0] OP_DEPOSIT = 3'd4;

  // Response status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NOPAGE = 2'd1;
  localparam logic [1:0] STAT_FLAG   = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  cpu;
    logic [11:0] page;
  } alloc_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] granted_page;
    logic [15:0] ref_count;
    logic        returned_to_list;
  } alloc_rsp_t;

endpackage

// ===== hw/rtl/refcounted_page_allocator.sv =====
// Per-CPU free-list page allocator with per-page reference counts.
// Depends on refalloc_pkg for request/response types and codes.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------
//   in_     | input     | in_valid/in_stall  | alloc_req_t (op, cpu, page)
//   out_    | output    | out_valid/out_stall| alloc_rsp_t (status, page, count, ret)
//
// A request is read, then written back: the accept edge reads the count and link
// memories into registers, and the write-back state modifies them, writes them
// back and loads the output register once the output is free. After reset a
// clearing pass zeroes all PAGES (4096 by default) entries of the count memory,
// with in_stall held high. A stalled response holds the write-back stage; a new
// request is still taken while a finished response waits.
`timescale 1ns / 1ps

module refcounted_page_allocator
  import refalloc_pkg::*;
#(
  parameter int PAGES      = 4096,
  parameter int CPUS       = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  alloc_req_t in_req,
  output logic       out_valid,
  input  logic       out_stall,
  output alloc_rsp_t out_rsp
);

  localparam int PW = $clog2(PAGES);
  localparam int CW = (CPUS > 1) ? $clog2(CPUS) : 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  // Map the requesting CPU onto an existing list
  function automatic logic [CW-1:0] cpu_wrap(input logic [2:0] cpu);
    logic [CW-1:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      if (cpu == 3'(k)) r = CW'(k % CPUS);
    end
    return r;
  endfunction

  // Fit a count into the 16-bit response field
  function automatic logic [15:0] cnt16(input logic [COUNT_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  // Control state
  state_t          state_r, state_nxt;
  logic [PW-1:0]   clr_idx_r;
  logic [PW-1:0]   list_head_r [CPUS];
  logic [CPUS-1:0] list_ne_r;

  // Request captured at accept
  logic [2:0]      op_r;
  logic [11:0]     req_page_r;
  logic [PW-1:0]   idx_r;
  logic            page_ok_r;
  logic            found_r;
  logic [CW-1:0]   sel_cpu_r;
  logic [PW-1:0]   head_sel_r;
  logic            ne_sel_r;

  // Memories and their read registers
  logic [COUNT_BITS-1:0] rc_mem   [PAGES];
  logic [PW:0]           link_mem [PAGES];
  logic [COUNT_BITS-1:0] rc_rd_r;
  logic [PW:0]           link_rd_r;

  // Output register
  logic       out_valid_r;
  alloc_rsp_t out_rsp_r;

  // Accept-side signals
  logic            in_acc;
  logic [CW-1:0]   cpu_c;
  logic [CW-1:0]   steal_src;
  logic            steal_any;
  logic            found;
  logic [CW-1:0]   sel_cpu;
  logic [PW-1:0]   head_sel;
  logic [31:0]     page_wide;
  logic            page_ok;
  logic [PW-1:0]   page_idx;
  logic [PW-1:0]   rd_addr;

  // Write-back signals
  logic                  out_free;
  logic                  commit;
  alloc_rsp_t            rsp;
  logic                  rc_we;
  logic [COUNT_BITS-1:0] rc_wd;
  logic                  link_we;
  logic                  head_we;
  logic [PW-1:0]         head_wd;
  logic                  ne_wd;
  logic [31:0]           idx_wide;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign commit    = (state_r == S_EXEC) && out_free;

  // Pick the list to pop: own list first, else lowest non-empty other list
  always_comb begin
    cpu_c     = cpu_wrap(in_req.cpu);
    steal_src = '0;
    steal_any = 1'b0;
    for (int i = CPUS - 1; i >= 0; i--) begin
      if (list_ne_r[i]) begin
        steal_src = CW'(i);
        steal_any = 1'b1;
      end
    end
    found     = list_ne_r[cpu_c] || steal_any;
    sel_cpu   = (in_req.op == OP_ALLOC && !list_ne_r[cpu_c]) ? steal_src : cpu_c;
    head_sel  = list_head_r[sel_cpu];
    page_wide = 32'(in_req.page);
    page_ok   = (page_wide < 32'(PAGES));
    page_idx  = page_wide[PW-1:0];
    rd_addr   = (in_req.op == OP_ALLOC) ? head_sel : page_idx;
  end

  // Capture the request at accept
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r       <= in_req.op;
      req_page_r <= in_req.page;
      idx_r      <= rd_addr;
      page_ok_r  <= page_ok;
      found_r    <= found;
      sel_cpu_r  <= sel_cpu;
      head_sel_r <= head_sel;
      ne_sel_r   <= list_ne_r[sel_cpu];
    end
  end

  // Modify: build the response and the write-back
  always_comb begin
    rsp.status           = STAT_OK;
    rsp.granted_page     = req_page_r;
    rsp.ref_count        = '0;
    rsp.returned_to_list = 1'b0;
    rc_we    = 1'b0;
    rc_wd    = rc_rd_r;
    link_we  = 1'b0;
    head_we  = 1'b0;
    head_wd  = idx_r;
    ne_wd    = 1'b1;
    idx_wide = 32'(idx_r);
    case (op_r)
      OP_ALLOC: begin
        if (!found_r) begin
          rsp.status       = STAT_NOPAGE;
          rsp.granted_page = '0;
        end else begin
          rc_we            = 1'b1;
          rc_wd            = COUNT_BITS'(1);
          rsp.granted_page = idx_wide[11:0];
          rsp.ref_count    = 16'd1;
          head_we          = 1'b1;
          head_wd          = link_rd_r[PW-1:0];
          ne_wd            = link_rd_r[PW];
        end
      end
      OP_FREE: begin
        if (page_ok_r) begin
          if (rc_rd_r == '0) begin
            rsp.status = STAT_FLAG;
          end else begin
            rc_we = 1'b1;
            rc_wd = rc_rd_r - COUNT_BITS'(1);
            if (rc_rd_r == COUNT_BITS'(1)) begin
              link_we              = 1'b1;
              head_we              = 1'b1;
              rsp.returned_to_list = 1'b1;
            end else begin
              rsp.ref_count = cnt16(rc_rd_r - COUNT_BITS'(1));
            end
          end
        end
      end
      OP_INC: begin
        if (page_ok_r) begin
          if (rc_rd_r == CNT_MAX) begin
            rsp.status    = STAT_FLAG;
            rsp.ref_count = cnt16(rc_rd_r);
          end else begin
            rc_we         = 1'b1;
            rc_wd         = rc_rd_r + COUNT_BITS'(1);
            rsp.ref_count = cnt16(rc_rd_r + COUNT_BITS'(1));
          end
        end
      end
      OP_QUERY: begin
        if (page_ok_r) rsp.ref_count = cnt16(rc_rd_r);
      end
      OP_DEPOSIT: begin
        if (page_ok_r) begin
          link_we       = 1'b1;
          head_we       = 1'b1;
          rsp.ref_count = cnt16(rc_rd_r);
        end
      end
      default: begin
      end
    endcase
  end

  // Count memory: clearing pass, write-back and read on accept
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      rc_mem[clr_idx_r] <= '0;
    end else if (commit && rc_we) begin
      rc_mem[idx_r] <= rc_wd;
    end
    if (in_acc) rc_rd_r <= rc_mem[rd_addr];
  end

  // Link memory: push writes the old head and its non-empty bit
  always_ff @(posedge clk) begin
    if (commit && link_we) link_mem[idx_r] <= {ne_sel_r, head_sel_r};
    if (in_acc) link_rd_r <= link_mem[rd_addr];
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_idx_r == PW'(PAGES - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_acc) state_nxt = S_EXEC;
      S_EXEC:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Advance control state, list heads and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      list_ne_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CPUS; i++) list_head_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_idx_r <= clr_idx_r + PW'(1);
      if (commit && head_we) begin
        list_head_r[sel_cpu_r] <= head_wd;
        list_ne_r[sel_cpu_r]   <= ne_wd;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the response payload
  always_ff @(posedge clk) begin
    if (commit) out_rsp_r <= rsp;
  end

  // An accepted request is worked on in the next cycle
  a_acc_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_EXEC)
    else $error("accepted request did not enter write-back");

  // A response appears only after a write-back cycle
  a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("response without write-back");

  // A push leaves its list non-empty
  a_push_ne: assert property (@(posedge clk) disable iff (!rst_n)
    commit && head_we && op_r != OP_ALLOC |=> list_ne_r[$past(sel_cpu_r)])
    else $error("push left list empty");

  // The clearing pass ends after the last entry
  a_clr_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR && clr_idx_r == PW'(PAGES - 1) |=> state_r == S_IDLE)
    else $error("clearing pass did not finish");

endmodule

// ===== tb/refcounted_page_allocator_checker.sv =====
`timescale 1ns / 1ps
// Response checker for refcounted_page_allocator: mirrors the per-CPU free lists
// and page counts, predicts each response when its request is taken, compares in order.
// Depends on refalloc_pkg for the request/response structs, opcodes and status codes.

module refcounted_page_allocator_checker
  import refalloc_pkg::*;
#(
  parameter int PAGES = 4096,
  parameter int CPUS  = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  alloc_req_t in_req,
  input  logic       out_valid,
  input  logic       out_stall,
  input  alloc_rsp_t out_rsp,
  output int         fail_count,
  output int         pending
);

  // Mirror of the allocator state
  logic [11:0] link_next [PAGES];
  logic        link_cont [PAGES];
  logic [15:0] use_count [PAGES];
  logic [11:0] head_page [CPUS];
  logic        head_valid [CPUS];

  alloc_rsp_t  outcome_q [$];
  int          errors;

  // Push a page onto the head of one CPU's list
  function automatic void list_push(logic [2:0] cpu, logic [11:0] pg);
    link_next[pg] = head_page[cpu];
    link_cont[pg] = head_valid[cpu];
    head_page[cpu] = pg;
    head_valid[cpu] = 1'b1;
  endfunction

  // Apply one request to the mirror and return the response it should give
  function automatic alloc_rsp_t alloc_outcome(alloc_req_t req);
    alloc_rsp_t  rsp;
    logic [2:0]  src;
    logic        found;
    logic [11:0] pg;
    rsp = '0;
    rsp.granted_page = req.page;
    case (req.op)
      OP_ALLOC: begin
        src = req.cpu;
        found = head_valid[req.cpu];
        // steal from the lowest-numbered other CPU with pages
        for (int i = 0; i < CPUS; i++) begin
          if (!found && i != req.cpu && head_valid[i]) begin
            src = 3'(i);
            found = 1'b1;
          end
        end
        if (!found) begin
          rsp.status = STAT_NOPAGE;
          rsp.granted_page = '0;
        end else begin
          pg = head_page[src];
          head_page[src] = link_next[pg];
          head_valid[src] = link_cont[pg];
          use_count[pg] = 16'd1;
          rsp.granted_page = pg;
          rsp.ref_count = 16'd1;
        end
      end
      OP_FREE: begin
        if (use_count[req.page] == '0) begin
          rsp.status = STAT_FLAG;
        end else begin
          use_count[req.page] = use_count[req.page] - 16'd1;
          if (use_count[req.page] == '0) begin
            list_push(req.cpu, req.page);
            rsp.returned_to_list = 1'b1;
          end else begin
            rsp.ref_count = use_count[req.page];
          end
        end
      end
      OP_INC: begin
        // hold at the top of the count range
        if (use_count[req.page] == '1) begin
          rsp.status = STAT_FLAG;
        end else begin
          use_count[req.page] = use_count[req.page] + 16'd1;
        end
        rsp.ref_count = use_count[req.page];
      end
      OP_QUERY: begin
        rsp.ref_count = use_count[req.page];
      end
      OP_DEPOSIT: begin
        list_push(req.cpu, req.page);
        rsp.ref_count = use_count[req.page];
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  // Predict on request accept, compare on response accept
  always @(posedge clk) begin
    alloc_rsp_t want;
    if (!rst_n) begin
      outcome_q.delete();
      for (int p = 0; p < PAGES; p++) begin
        link_next[p] = '0;
        link_cont[p] = 1'b0;
        use_count[p] = '0;
      end
      for (int c = 0; c < CPUS; c++) begin
        head_page[c] = '0;
        head_valid[c] = 1'b0;
      end
    end else begin
      if (in_valid && !in_stall) begin
        outcome_q.push_back(alloc_outcome(in_req));
      end
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          errors++;
          $error("response with no request outstanding");
        end else begin
          want = outcome_q.pop_front();
          if (out_rsp.status !== want.status) begin
            errors++;
            $error("status: expected %0d, got %0d", want.status, out_rsp.status);
          end
          if (out_rsp.granted_page !== want.granted_page) begin
            errors++;
            $error("granted_page: expected %0d, got %0d", want.granted_page,
                   out_rsp.granted_page);
          end
          if (out_rsp.ref_count !== want.ref_count) begin
            errors++;
            $error("ref_count: expected %0d, got %0d", want.ref_count, out_rsp.ref_count);
          end
          if (out_rsp.returned_to_list !== want.returned_to_list) begin
            errors++;
            $error("returned_to_list: expected %0d, got %0d", want.returned_to_list,
                   out_rsp.returned_to_list);
          end
        end
      end
    end
    fail_count <= errors;
    pending <= outcome_q.size();
  end

endmodule

// ===== tb/refcounted_page_allocator_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for refcounted_page_allocator: drives request traffic and response
// back-pressure, runs the checker beside the block and prints the verdict.
// Depends on refalloc_pkg, refcounted_page_allocator and refcounted_page_allocator_checker.

module refcounted_page_allocator_tb;
  import refalloc_pkg::*;

  localparam logic [2:0]  OP_RSVD_LO      = 3'd5;
  localparam logic [2:0]  OP_RSVD_HI      = 3'd7;
  localparam int          RANDOM_ITEMS    = 800;
  localparam int          RUN_INCS        = 40;
  localparam logic [11:0] INC_PAGE        = 12'd3000;
  localparam int          PRESSURE_AT     = 300;
  localparam int          PRESSURE_CYCLES = 400;
  localparam int          IDLE_LIMIT      = 20000;
  localparam int          DRAIN_CYCLES    = 20;

  typedef enum int unsigned {MIX_FILL, MIX_DRAIN, MIX_BLEND} mix_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  alloc_req_t in_req = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  alloc_rsp_t out_rsp;

  int          fail_count;
  int          pending;
  int          sent_count = 0;
  int          idle_cycles = 0;
  int unsigned burst_left = 0;
  logic        steady = 1'b0;
  logic        pressure_done = 1'b0;

  refcounted_page_allocator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  refcounted_page_allocator_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_rsp    (out_rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  // Offer one request, hold it until taken, then maybe drop valid for a gap
  task automatic offer(input logic [2:0] op, input logic [2:0] cpu, input logic [11:0] page);
    int unsigned gap;
    in_req <= {op, cpu, page};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else if (!steady) begin
      burst_left = $urandom_range(0, 23);
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Weighted opcode choice; fill favors deposits, drain favors allocs
  function automatic logic [2:0] pick_op(mix_t mix);
    int unsigned roll;
    int unsigned t_alloc, t_free, t_inc, t_query, t_dep;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        t_alloc = 20; t_free = 30; t_inc = 40; t_query = 50; t_dep = 95;
      end
      MIX_DRAIN: begin
        t_alloc = 55; t_free = 70; t_inc = 80; t_query = 90; t_dep = 95;
      end
      default: begin
        t_alloc = 25; t_free = 50; t_inc = 70; t_query = 80; t_dep = 95;
      end
    endcase
    if (roll < t_alloc) return OP_ALLOC;
    else if (roll < t_free) return OP_FREE;
    else if (roll < t_inc) return OP_INC;
    else if (roll < t_query) return OP_QUERY;
    else if (roll < t_dep) return OP_DEPOSIT;
    else return 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
  endfunction

  // Request stream and verdict
  initial begin : stimulus
    int          issued;
    int unsigned round_len;
    int unsigned roll;
    mix_t        mix;
    logic [11:0] pg;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty lists, zero-count free, stealing, push on free, odd ops
    offer(OP_ALLOC, 3'd3, 12'd0);
    offer(OP_FREE, 3'd0, 12'd5);
    offer(OP_QUERY, 3'd7, 12'hFFF);
    offer(OP_INC, 3'd6, 12'hFFF);
    offer(OP_DEPOSIT, 3'd7, 12'hFFF);
    offer(OP_DEPOSIT, 3'd0, 12'h000);
    offer(OP_DEPOSIT, 3'd5, 12'hAAA);
    offer(OP_DEPOSIT, 3'd5, 12'h555);
    offer(OP_ALLOC, 3'd5, 12'd0);
    offer(OP_ALLOC, 3'd2, 12'hFFF);
    offer(OP_ALLOC, 3'd2, 12'd0);
    offer(OP_INC, 3'd1, 12'h000);
    offer(OP_FREE, 3'd4, 12'h000);
    offer(OP_FREE, 3'd2, 12'h000);
    offer(OP_FREE, 3'd2, 12'h000);
    for (int o = OP_RSVD_LO; o <= OP_RSVD_HI; o++) offer(3'(o), 3'd7, 12'hFFF);
    // page already on a list: links to itself
    offer(OP_DEPOSIT, 3'd7, 12'hFFF);
    offer(OP_ALLOC, 3'd7, 12'd0);
    offer(OP_ALLOC, 3'd7, 12'd0);
    offer(OP_ALLOC, 3'd1, 12'd0);
    offer(OP_QUERY, 3'd0, 12'hFFF);

    // Run one count up with back-to-back increments, then query and free it
    steady = 1'b1;
    repeat (RUN_INCS) offer(OP_INC, 3'd3, INC_PAGE);
    repeat (2) offer(OP_INC, 3'd4, INC_PAGE);
    offer(OP_QUERY, 3'd3, INC_PAGE);
    offer(OP_FREE, 3'd3, INC_PAGE);
    steady = 1'b0;

    // Random rounds over a small working set of pages
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      mix = mix_t'($urandom_range(0, 2));
      round_len = $urandom_range(30, 80);
      repeat (round_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 80) pg = 12'($urandom_range(0, 47));
        else if (roll < 95) pg = 12'($urandom);
        else pg = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        offer(pick_op(mix), 3'($urandom_range(0, 7)), pg);
        issued++;
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding responses
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("refcounted_page_allocator_tb: PASS");
    end else begin
      $display("refcounted_page_allocator_tb: FAIL");
    end
    $finish;
  end

  // Response back-pressure: random segments, plus one long hold-off
  initial begin : rx_pattern
    int unsigned seg_len;
    int unsigned style;
    logic        hold;
    @(posedge clk);
    forever begin
      if (!pressure_done && sent_count >= PRESSURE_AT) begin
        out_stall <= 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge clk);
        pressure_done = 1'b1;
      end else begin
        seg_len = $urandom_range(1, 48);
        style = $urandom_range(0, 3);
        repeat (seg_len) begin
          case (style)
            0: hold = 1'b0;
            1: hold = ($urandom_range(0, 3) == 0);
            2: hold = ($urandom_range(0, 3) != 0);
            default: hold = ~out_stall;
          endcase
          out_stall <= hold;
          @(posedge clk);
        end
      end
    end
  end

  // Watchdog: end the run when no handshake happens for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("refcounted_page_allocator_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
